>>> src/dsms_pkg.sv
// ----------------------------------------------------------------------------
// dsms_pkg
// Shared types, codes and tables for the dual stepper microstep sequencer.
// ----------------------------------------------------------------------------
package dsms_pkg;

   localparam int ODOMETRY_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLARITY  = 2'd1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_DRIVE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_ZERO  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      DRV_FWD   = 3'd0,
      DRV_REV   = 3'd1,
      DRV_LEFT  = 3'd2,
      DRV_RIGHT = 3'd3,
      DRV_STOP  = 3'd4
   } drive_op_type;

   typedef enum logic [1:0] {
      RS_COAST = 2'd0,
      RS_BRAKE = 2'd1,
      RS_RUN   = 2'd2
   } run_state_type;

   typedef enum logic [1:0] {
      MODE_MICRO = 2'd0,
      MODE_FULL  = 2'd1,
      MODE_HALF  = 2'd2
   } step_mode_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] drive_op;
   } req_type;

   typedef struct packed {
      logic [7:0]  left_a_plus;
      logic [7:0]  left_a_minus;
      logic [7:0]  left_b_plus;
      logic [7:0]  left_b_minus;
      logic [7:0]  right_a_plus;
      logic [7:0]  right_a_minus;
      logic [7:0]  right_b_plus;
      logic [7:0]  right_b_minus;
      logic [1:0]  output_mode;
      logic        driver_awake;
      logic [31:0] executed_steps;
   } rsp_type;

   // compare values of one motor
   typedef struct packed {
      logic [7:0] a_plus;
      logic [7:0] a_minus;
      logic [7:0] b_plus;
      logic [7:0] b_minus;
   } coil_type;

   localparam logic [7:0] SINE_TAB [32] = '{
      8'd128, 8'd152, 8'd176, 8'd198, 8'd218, 8'd234, 8'd245, 8'd253,
      8'd255, 8'd253, 8'd245, 8'd234, 8'd218, 8'd198, 8'd176, 8'd152,
      8'd128, 8'd103, 8'd79,  8'd57,  8'd37,  8'd21,  8'd10,  8'd2,
      8'd0,   8'd2,   8'd10,  8'd21,  8'd37,  8'd57,  8'd79,  8'd103
   };

   // bits 3..0: A+ A- B+ B-
   localparam logic [3:0] FULL_TAB [4] = '{4'hA, 4'h6, 4'h5, 4'h9};
   localparam logic [3:0] HALF_TAB [8] = '{
      4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9, 4'h8
   };

   localparam logic [7:0] PWM_FULL = 8'd255;

   function automatic logic [4:0] mode_mask(input logic [1:0] mode);
      logic [4:0] m;
      case (mode)
         MODE_FULL: m = 5'd3;
         MODE_HALF: m = 5'd7;
         default:   m = 5'd31;
      endcase
      return m;
   endfunction

endpackage

>>> src/dsms_coil_lut.sv
// ----------------------------------------------------------------------------
// dsms_coil_lut
// Maps a step index to the four coil compare values of one motor.
// ----------------------------------------------------------------------------
module dsms_coil_lut
   import dsms_pkg::*;
(
   input  logic [1:0] step_mode,
   input  logic [4:0] index,
   output coil_type   coil
);

   logic [3:0] bits;
   logic [4:0] idx_b;
   logic [7:0] va;
   logic [7:0] vb;

   assign idx_b = index + 5'd8;   // B phase leads by a quarter period
   assign va    = SINE_TAB[index];
   assign vb    = SINE_TAB[idx_b];

   always_comb begin
      bits = 4'h0;
      coil = '0;
      case (step_mode)
         MODE_FULL, MODE_HALF: begin
            bits = (step_mode == MODE_FULL) ? FULL_TAB[index[1:0]] : HALF_TAB[index[2:0]];
            coil.a_plus  = bits[3] ? PWM_FULL : 8'd0;
            coil.a_minus = bits[2] ? PWM_FULL : 8'd0;
            coil.b_plus  = bits[1] ? PWM_FULL : 8'd0;
            coil.b_minus = bits[0] ? PWM_FULL : 8'd0;
         end
         default: begin
            // micro mode; unused code 3 too
            coil.a_plus  = va;
            coil.a_minus = PWM_FULL - va;
            coil.b_plus  = vb;
            coil.b_minus = PWM_FULL - vb;
         end
      endcase
   end

endmodule

>>> src/dual_stepper_microstep_sequencer_core.sv
// ----------------------------------------------------------------------------
// dual_stepper_microstep_sequencer_core: two-motor stepper coil sequencer.
// A req beat is held in the input register, then its result in the result register;
// one beat per cycle sustained while rsp is not stalled, set by the state update.
// Synchronous reset: coast, indices 0, signs left +1 / right -1, odometry 0.
// ----------------------------------------------------------------------------
module dual_stepper_microstep_sequencer_core
   import dsms_pkg::*;
#(
   parameter int ODOMETRY_BITS = ODOMETRY_BITS_DEFAULT
)(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int OB = ODOMETRY_BITS;

   // ---------------------------------------------------------------
   // Configuration registers, always ready. The user writes only while the
   // pipeline is idle; not enforced, no interlock against items in flight.
   // ---------------------------------------------------------------
   logic [1:0] step_mode_ff, step_mode_in;
   logic       polarity_ff, polarity_in;

   assign csr_ready = 1'b1;

   always_comb begin
      step_mode_in = step_mode_ff;
      polarity_in  = polarity_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_MODE: step_mode_in = csr_data[1:0];
            CSR_POLARITY:  polarity_in  = csr_data[0];
            default: ;   // writes beyond the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_mode_ff <= MODE_MICRO;
         polarity_ff  <= 1'b0;
      end else begin
         step_mode_ff <= step_mode_in;
         polarity_ff  <= polarity_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake. Input register in front, result register behind:
   // an item may sit in the input stage while a result is stalled.
   // ---------------------------------------------------------------
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    adv;        // result register can take a new beat
   logic    req_take;   // request beat accepted
   logic    fire;       // input stage item retires into result register

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !adv;
   assign req_take  = req_valid && !req_stall;
   assign fire      = in_valid_ff && adv;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)
         in_valid_in = 1'b1;
      else if (fire)
         in_valid_in = 1'b0;
      rsp_valid_in = adv ? in_valid_ff : rsp_valid_ff;
   end

   // ---------------------------------------------------------------
   // Sequencer state. Signs are kept as a negative flag (signs are
   // only ever +1 or -1).
   // ---------------------------------------------------------------
   run_state_type   run_ff, run_in;
   logic [4:0]      l_idx_ff, l_idx_in, r_idx_ff, r_idx_in;
   logic            l_neg_ff, l_neg_in, r_neg_ff, r_neg_in;
   logic [OB-1:0]   l_odo_ff, l_odo_in, r_odo_ff, r_odo_in;
   coil_type        l_cmp_ff, l_cmp_in, r_cmp_ff, r_cmp_in;
   coil_type        l_coil, r_coil;
   logic [4:0]      mask;
   logic            running;
   logic            load_cmp;

   assign mask    = mode_mask(step_mode_ff);
   assign running = (run_ff == RS_RUN);

   always_comb begin
      run_in   = run_ff;
      l_idx_in = l_idx_ff;
      r_idx_in = r_idx_ff;
      l_neg_in = l_neg_ff;
      r_neg_in = r_neg_ff;
      l_odo_in = l_odo_ff;
      r_odo_in = r_odo_ff;
      load_cmp = 1'b0;
      case (in_data_ff.opcode)
         OP_TICK: begin
            // tick while stopped changes nothing
            if (running) begin
               l_idx_in = (l_idx_ff + (l_neg_ff ? 5'd31 : 5'd1)) & mask;
               r_idx_in = (r_idx_ff + (r_neg_ff ? 5'd31 : 5'd1)) & mask;
               l_odo_in = l_odo_ff + {{(OB-1){1'b0}}, 1'b1};
               r_odo_in = r_odo_ff + {{(OB-1){1'b0}}, 1'b1};
               load_cmp = 1'b1;
            end
         end
         OP_DRIVE: begin
            // run commands: polarity flips both base signs; the indices
            // stay put and the compares reload from them
            case (in_data_ff.drive_op)
               DRV_FWD: begin
                  l_neg_in = polarity_ff;
                  r_neg_in = !polarity_ff;
                  run_in   = RS_RUN;
                  load_cmp = 1'b1;
               end
               DRV_REV: begin
                  l_neg_in = !polarity_ff;
                  r_neg_in = polarity_ff;
                  run_in   = RS_RUN;
                  load_cmp = 1'b1;
               end
               DRV_LEFT: begin
                  l_neg_in = polarity_ff;
                  r_neg_in = polarity_ff;
                  run_in   = RS_RUN;
                  load_cmp = 1'b1;
               end
               DRV_RIGHT: begin
                  l_neg_in = !polarity_ff;
                  r_neg_in = !polarity_ff;
                  run_in   = RS_RUN;
                  load_cmp = 1'b1;
               end
               DRV_STOP:  run_in = RS_BRAKE;
               default:   run_in = RS_COAST;
            endcase
         end
         OP_CLEAR: begin
            l_odo_in = '0;
            r_odo_in = '0;
         end
         default: begin
            // zeroing the indices leaves the compares latched
            l_idx_in = 5'd0;
            r_idx_in = 5'd0;
         end
      endcase
   end

   // table lookups on the updated indices; a stale index from another
   // mode is masked inside the lookup
   dsms_coil_lut u_left_lut (
      .step_mode (step_mode_ff),
      .index     (l_idx_in),
      .coil      (l_coil)
   );

   dsms_coil_lut u_right_lut (
      .step_mode (step_mode_ff),
      .index     (r_idx_in),
      .coil      (r_coil)
   );

   assign l_cmp_in = load_cmp ? l_coil : l_cmp_ff;
   assign r_cmp_in = load_cmp ? r_coil : r_cmp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= RS_COAST;
         l_idx_ff <= 5'd0;
         r_idx_ff <= 5'd0;
         l_neg_ff <= 1'b0;
         r_neg_ff <= 1'b1;
         l_odo_ff <= '0;
         r_odo_ff <= '0;
         l_cmp_ff <= '0;
         r_cmp_ff <= '0;
      end else if (fire) begin
         run_ff   <= run_in;
         l_idx_ff <= l_idx_in;
         r_idx_ff <= r_idx_in;
         l_neg_ff <= l_neg_in;
         r_neg_ff <= r_neg_in;
         l_odo_ff <= l_odo_in;
         r_odo_ff <= r_odo_in;
         l_cmp_ff <= l_cmp_in;
         r_cmp_ff <= r_cmp_in;
      end
   end

   // ---------------------------------------------------------------
   // Result beat, taken after the update. Step count is the halved
   // sum of both counters, kept to its low 32 bits.
   // ---------------------------------------------------------------
   logic [OB:0]    odo_sum;
   logic [OB+31:0] odo_half_ext;

   assign odo_sum      = {1'b0, l_odo_in} + {1'b0, r_odo_in};
   assign odo_half_ext = {32'd0, odo_sum[OB:1]};

   always_comb begin
      rsp_data_in.left_a_plus    = l_cmp_in.a_plus;
      rsp_data_in.left_a_minus   = l_cmp_in.a_minus;
      rsp_data_in.left_b_plus    = l_cmp_in.b_plus;
      rsp_data_in.left_b_minus   = l_cmp_in.b_minus;
      rsp_data_in.right_a_plus   = r_cmp_in.a_plus;
      rsp_data_in.right_a_minus  = r_cmp_in.a_minus;
      rsp_data_in.right_b_plus   = r_cmp_in.b_plus;
      rsp_data_in.right_b_minus  = r_cmp_in.b_minus;
      rsp_data_in.output_mode    = run_in;
      rsp_data_in.driver_awake   = (run_in != RS_COAST);
      rsp_data_in.executed_steps = odo_half_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_data_ff <= req_data;
      if (fire)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // both counters step and clear together
   a_odo_match: assert property (@(posedge clock) disable iff (reset)
      l_odo_ff == r_odo_ff)
      else $error("left and right odometry diverged");

   // an item held in the input stage is not lost while the output stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv |=> in_valid_ff)
      else $error("input stage dropped an item");

   // awake flag follows the mode reported in the same beat
   a_awake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.driver_awake == (rsp_data_ff.output_mode != RS_COAST)))
      else $error("driver_awake inconsistent with output_mode");

endmodule
